FILE: sv/sapq_pkg.sv
// Shared constants and controller/datapath interface types for the priority queue.
`timescale 1ns / 1ps

package sapq_pkg;

    localparam int VALUE_W       = 32;
    localparam int PRIO_W        = 16;
    localparam int STATUS_W      = 2;
    localparam int FILL_W        = 5;
    localparam int CAP_W         = 5;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Request codes on func
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic                load;
        logic                insert;
        logic                remove;
        logic                finish;
        logic [STATUS_W-1:0] code;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_deq;
        logic empty;
        logic full;
    } sts_t;

endpackage

FILE: sv/sapq_ctrl.sv
// Controller state machine: accepts a request and issues the operation for it.
`timescale 1ns / 1ps

module sapq_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  sapq_pkg::sts_t  sts,
    output sapq_pkg::cmd_t  cmd
);
    import sapq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        cmd        = '0;
        cmd.code   = ST_DONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                    busy_next  = 1'b1;
                end
            end
            S_RUN:
            begin
                cmd.finish = 1'b1;
                if (sts.req_deq == FUNC_DEQ)
                begin
                    if (sts.empty)
                        cmd.code = ST_EMPTY;
                    else
                        cmd.remove = 1'b1;
                end
                else
                begin
                    if (sts.full)
                        cmd.code = ST_FULL;
                    else
                        cmd.insert = 1'b1;
                end
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

FILE: sv/sapq_dp.sv
// Datapath: row of entry cells kept in descending priority order, count and result registers.
`timescale 1ns / 1ps

module sapq_dp
#(
    parameter int DEPTH = sapq_pkg::DEPTH_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sapq_pkg::cmd_t                         cmd,
    output sapq_pkg::sts_t                         sts,
    input  logic                                   cfg_we,
    input  logic [sapq_pkg::CAP_W-1:0]             cfg_data,
    input  logic                                   func,
    input  logic signed [sapq_pkg::VALUE_W-1:0]    item_value,
    input  logic [sapq_pkg::PRIO_W-1:0]            item_priority,
    output logic                                   done,
    output logic signed [sapq_pkg::VALUE_W-1:0]    out_value,
    output logic [sapq_pkg::PRIO_W-1:0]            out_priority,
    output logic [sapq_pkg::STATUS_W-1:0]          status,
    output logic [sapq_pkg::FILL_W-1:0]            fill_count
);
    import sapq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Cell 0 holds the highest priority; equal priorities keep arrival order.
    logic [VALUE_W-1:0]  entry_value_reg  [DEPTH];
    logic [VALUE_W-1:0]  entry_value_next [DEPTH];
    logic [PRIO_W-1:0]   entry_prio_reg   [DEPTH];
    logic [PRIO_W-1:0]   entry_prio_next  [DEPTH];

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CAP_W-1:0]    capacity_reg;

    logic                req_func_reg;
    logic [VALUE_W-1:0]  req_value_reg;
    logic [PRIO_W-1:0]   req_prio_reg;

    logic                done_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [PRIO_W-1:0]   out_prio_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [FILL_W-1:0]   fill_reg;

    logic [DEPTH-1:0]    cell_valid;
    logic [DEPTH-1:0]    cell_lt;
    logic [DEPTH-1:0]    prev_lt;
    logic [LIM_W-1:0]    limit;

    always_comb
    begin
        if (LIM_W'(capacity_reg) < LIM_W'(DEPTH))
            limit = LIM_W'(capacity_reg);
        else
            limit = LIM_W'(DEPTH);
    end

    assign sts.req_deq = req_func_reg;
    assign sts.empty   = (count_reg == '0);
    assign sts.full    = (LIM_W'(count_reg) >= limit);

    // Per-cell compare against the pending priority
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_valid[i] = (CNT_W'(i) < count_reg);
            cell_lt[i]    = cell_valid[i] && (entry_prio_reg[i] < req_prio_reg);
        end
        prev_lt[0] = 1'b0;
        for (int i = 1; i < DEPTH; i++)
            prev_lt[i] = cell_lt[i-1];
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            entry_value_next[i] = entry_value_reg[i];
            entry_prio_next[i]  = entry_prio_reg[i];
        end
        count_next = count_reg;

        if (cmd.insert)
        begin
            // Open a slot above the first lower-priority cell, push the rest down.
            entry_value_next[0] = (cell_lt[0] || !cell_valid[0]) ? req_value_reg
                                                                 : entry_value_reg[0];
            entry_prio_next[0]  = (cell_lt[0] || !cell_valid[0]) ? req_prio_reg
                                                                 : entry_prio_reg[0];
            for (int i = 1; i < DEPTH; i++)
            begin
                if (prev_lt[i])
                begin
                    entry_value_next[i] = entry_value_reg[i-1];
                    entry_prio_next[i]  = entry_prio_reg[i-1];
                end
                else if (cell_lt[i] || !cell_valid[i])
                begin
                    entry_value_next[i] = req_value_reg;
                    entry_prio_next[i]  = req_prio_reg;
                end
            end
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.remove)
        begin
            // Advance every cell one place towards the head.
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                entry_value_next[i] = entry_value_reg[i+1];
                entry_prio_next[i]  = entry_prio_reg[i+1];
            end
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            entry_value_reg[i] <= entry_value_next[i];
            entry_prio_reg[i]  <= entry_prio_next[i];
        end
        if (cmd.load)
        begin
            req_func_reg  <= func;
            req_value_reg <= item_value;
            req_prio_reg  <= item_priority;
        end
        if (cmd.finish)
        begin
            out_value_reg <= cmd.remove ? entry_value_reg[0] : '0;
            out_prio_reg  <= cmd.remove ? entry_prio_reg[0] : '0;
            status_reg    <= cmd.code;
            fill_reg      <= FILL_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            capacity_reg <= CAP_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.finish;
            if (cfg_we)
                capacity_reg <= cfg_data;
        end
    end

    assign done         = done_reg;
    assign out_value    = out_value_reg;
    assign out_priority = out_prio_reg;
    assign status       = status_reg;
    assign fill_count   = fill_reg;

endmodule

FILE: sv/sorted_array_priority_queue.sv
// Top level of the sorted-array priority queue: controller plus entry datapath.
// A transaction taken with start high and busy low goes into the request registers and is
//   decided in the run state; its result is registered onto the result ports, marked by
//   done for exactly one cycle. Busy is high while the controller runs the insert or remove
//   across the whole cell row, so no new transaction is taken until the last is decided.
// Asynchronous reset: queue empty, capacity 16, no result pending; receiver cannot stall.
`timescale 1ns / 1ps

module sorted_array_priority_queue
#(
    parameter int DEPTH = sapq_pkg::DEPTH_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   func,
    input  logic signed [sapq_pkg::VALUE_W-1:0]    item_value,
    input  logic [sapq_pkg::PRIO_W-1:0]            item_priority,
    input  logic                                   cfg_we,
    input  logic [sapq_pkg::CAP_W-1:0]             cfg_data,
    output logic                                   done,
    output logic signed [sapq_pkg::VALUE_W-1:0]    out_value,
    output logic [sapq_pkg::PRIO_W-1:0]            out_priority,
    output logic [sapq_pkg::STATUS_W-1:0]          status,
    output logic [sapq_pkg::FILL_W-1:0]            fill_count
);
    import sapq_pkg::*;

    // Command and status between the state machine and the cell row
    cmd_t cmd;
    sts_t sts;

    // Controller: take a transaction when idle, then decide in the next cycle whether it
    // inserts, removes, or is dropped as full or empty.
    sapq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Datapath: the entries sit in a row of cells sorted by descending priority, so a
    // remove always takes cell 0 and shifts the row up; an insert compares every cell in
    // parallel and pushes the lower-priority tail down by one place.
    sapq_dp
    #(
        .DEPTH (DEPTH)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .func          (func),
        .item_value    (item_value),
        .item_priority (item_priority),
        .done          (done),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .status        (status),
        .fill_count    (fill_count)
    );

endmodule

FILE: tb/sorted_array_priority_queue_test.sv
// Self-checking testbench for the sorted-array priority queue: directed cases, then random traffic.
`timescale 1ns / 1ps

module sorted_array_priority_queue_test;

    import sapq_pkg::*;

    localparam int QUEUE_DEPTH = DEPTH_DEFAULT;
    // Longest legal silence is a long sender gap plus the result latency; allow many times that.
    localparam int IDLE_LIMIT  = 600;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
    } entry_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]         prio;
        logic [STATUS_W-1:0]       code;
        logic [FILL_W-1:0]         fill;
    } outcome_t;

    logic                      clk           = 1'b0;
    logic                      rst_n         = 1'b0;
    logic                      start         = 1'b0;
    logic                      func          = FUNC_ENQ;
    logic signed [VALUE_W-1:0] item_value    = '0;
    logic [PRIO_W-1:0]         item_priority = '0;
    logic                      cfg_we        = 1'b0;
    logic [CAP_W-1:0]          cfg_data      = '0;
    logic                      busy;
    logic                      done;
    logic signed [VALUE_W-1:0] out_value;
    logic [PRIO_W-1:0]         out_priority;
    logic [STATUS_W-1:0]       status;
    logic [FILL_W-1:0]         fill_count;

    // Shadow copy of the queue, kept sorted by ascending priority (top entry at the back).
    entry_t           queue_shadow[$];
    logic [CAP_W-1:0] shadow_capacity = CAP_RESET;
    // Results still owed by the block, oldest first.
    outcome_t         outcomes_due[$];

    bit steady_sender = 1'b0;
    int mismatches    = 0;
    int idle_cycles   = 0;
    int n_requests    = 0;
    int n_stored      = 0;
    int n_served      = 0;
    int n_full        = 0;
    int n_empty       = 0;
    int deepest_fill  = 0;

    sorted_array_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .item_value   (item_value),
        .item_priority(item_priority),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .done         (done),
        .out_value    (out_value),
        .out_priority (out_priority),
        .status       (status),
        .fill_count   (fill_count)
    );

    always #5 clk = ~clk;

    // Apply one request to the shadow queue and return the result the block owes for it.
    function automatic outcome_t predict_queue_outcome(input logic op,
                                                       input logic signed [VALUE_W-1:0] v,
                                                       input logic [PRIO_W-1:0] p);
        outcome_t res;
        entry_t   ent;
        int       slot;
        int       limit;
        res.value = '0;
        res.prio  = '0;
        res.code  = ST_DONE;
        limit = (shadow_capacity < QUEUE_DEPTH) ? int'(shadow_capacity) : QUEUE_DEPTH;
        if (op == FUNC_ENQ) begin
            if (queue_shadow.size() >= limit) begin
                res.code = ST_FULL;
                n_full++;
            end else begin
                // Drop below every entry of higher or equal priority: ties leave in arrival order.
                slot = queue_shadow.size();
                while (slot > 0 && queue_shadow[slot-1].prio >= p)
                    slot--;
                ent.value = v;
                ent.prio  = p;
                queue_shadow.insert(slot, ent);
                n_stored++;
            end
        end else begin
            if (queue_shadow.size() == 0) begin
                res.code = ST_EMPTY;
                n_empty++;
            end else begin
                ent = queue_shadow.pop_back();
                res.value = ent.value;
                res.prio  = ent.prio;
                n_served++;
            end
        end
        res.fill = FILL_W'(queue_shadow.size());
        if (queue_shadow.size() > deepest_fill)
            deepest_fill = queue_shadow.size();
        return res;
    endfunction

    // Most gaps short, a few long; none at all while the sender is held steady.
    function automatic int pick_gap();
        int roll;
        if (steady_sender)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Lean on a handful of small priorities so ties are common.
    function automatic logic [PRIO_W-1:0] pick_priority();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return PRIO_W'($urandom_range(0, 3));
            5:       return PRIO_W'($urandom_range(65532, 65535));
            default: return PRIO_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Send one request: idle for a random gap, then hold start until the block takes it.
    task automatic issue_request(input logic op, input logic signed [VALUE_W-1:0] v,
                                 input logic [PRIO_W-1:0] p);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start         <= 1'b1;
        func          <= op;
        item_value    <= v;
        item_priority <= p;
        do
            @(posedge clk);
        while (busy);
        outcomes_due.push_back(predict_queue_outcome(op, v, p));
        n_requests++;
    endtask

    // Hold the sender off until every owed result has come back, then let the pipe settle.
    task automatic settle_queue();
        @(negedge clk);
        start <= 1'b0;
        while (outcomes_due.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        settle_queue();
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        @(posedge clk);
        shadow_capacity = cap;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Reset capacity: empty dequeues, extreme values and priorities, ties leaving in arrival order.
    task automatic test_order_and_empty();
        issue_request(FUNC_DEQ, pick_value(), pick_priority());
        issue_request(FUNC_ENQ, 32'sh7fffffff, 16'd5);
        issue_request(FUNC_ENQ, 32'sh80000000, 16'd5);
        issue_request(FUNC_ENQ, 32'sh00000000, 16'hffff);
        issue_request(FUNC_ENQ, -32'sd1, 16'd0);
        issue_request(FUNC_ENQ, 32'sh12345678, 16'd5);
        repeat (5) issue_request(FUNC_DEQ, pick_value(), pick_priority());
        issue_request(FUNC_DEQ, '1, '1);
    endtask

    // Capacity zero and one, then lower the limit below the current fill.
    task automatic test_capacity_limits();
        write_capacity(CAP_W'(0));
        issue_request(FUNC_ENQ, 32'sd77, 16'd9);
        issue_request(FUNC_DEQ, pick_value(), pick_priority());
        write_capacity(CAP_W'(1));
        issue_request(FUNC_ENQ, 32'sd1, 16'd1);
        issue_request(FUNC_ENQ, 32'sd2, 16'd2);
        issue_request(FUNC_DEQ, pick_value(), pick_priority());
        write_capacity(CAP_W'(3));
        repeat (4) issue_request(FUNC_ENQ, pick_value(), pick_priority());
        // Entries already held stay; enqueues report full until the count drops below the limit.
        write_capacity(CAP_W'(1));
        issue_request(FUNC_ENQ, 32'sd3, 16'd3);
        repeat (2) issue_request(FUNC_DEQ, pick_value(), pick_priority());
        issue_request(FUNC_ENQ, 32'sd4, 16'd4);
        issue_request(FUNC_DEQ, pick_value(), pick_priority());
        issue_request(FUNC_ENQ, 32'sd5, 16'd5);
        issue_request(FUNC_DEQ, pick_value(), pick_priority());
    endtask

    // Random traffic swinging between fill runs and drain runs, so full and empty both turn up.
    task automatic run_random_phase(input int count, input logic [CAP_W-1:0] cap,
                                    input bit steady);
        int  enq_bias;
        int  run_left;
        int  k;
        logic op;
        write_capacity(cap);
        steady_sender = steady;
        enq_bias = 80;
        run_left = $urandom_range(8, 40);
        for (k = 0; k < count; k++)
        begin
            if (run_left == 0)
            begin
                enq_bias = (enq_bias > 50) ? 25 : 80;
                run_left = $urandom_range(8, 40);
            end
            run_left--;
            // Halfway through, pause until the block has answered everything.
            if (k == count / 2)
                settle_queue();
            op = ($urandom_range(0, 99) < enq_bias) ? FUNC_ENQ : FUNC_DEQ;
            issue_request(op, pick_value(), pick_priority());
        end
        steady_sender = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_phase(150, CAP_W'(31), 1'b0);
        run_random_phase(100, CAP_W'(1), 1'b0);
        run_random_phase(150, CAP_W'(16), 1'b1);
        run_random_phase(120, CAP_W'(5), 1'b0);
        run_random_phase(40, CAP_W'(0), 1'b0);
        run_random_phase(150, CAP_W'(17), 1'b0);
        run_random_phase(150, CAP_W'($urandom_range(2, 15)), 1'b0);
        run_random_phase(200, CAP_W'(16), 1'b0);
    endtask

    function automatic void match_field(input string label, input logic [VALUE_W-1:0] want,
                                        input logic [VALUE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            mismatches++;
        end
    endfunction

    // Take each result in the one cycle done is high and compare it with the oldest owed result.
    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n && done)
        begin
            if (outcomes_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual value %0h status %0d",
                         $time, out_value, status);
                mismatches++;
            end
            else
            begin
                want = outcomes_due.pop_front();
                match_field("out_value", want.value, out_value);
                match_field("out_priority", VALUE_W'(want.prio), VALUE_W'(out_priority));
                match_field("status", VALUE_W'(want.code), VALUE_W'(status));
                match_field("fill_count", VALUE_W'(want.fill), VALUE_W'(fill_count));
            end
        end
    end

    // Watchdog: count cycles in which no transaction is taken in either direction.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d results still owed",
                     $time, IDLE_LIMIT, outcomes_due.size());
            $display("sorted_array_priority_queue regression: fail");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_order_and_empty();
        test_capacity_limits();
        test_random_traffic();

        // Drain: wait for every owed result, then a few cycles to catch any stray strobe.
        settle_queue();
        repeat (4) @(posedge clk);

        $display("Covered %0d requests: %0d stored, %0d served, %0d full, %0d empty",
                 n_requests, n_stored, n_served, n_full, n_empty);
        $display("Capacities 0, 1, 3, 5, 16, 17, 31 and a random middle one; deepest fill %0d",
                 deepest_fill);
        if (mismatches == 0)
            $display("sorted_array_priority_queue regression: pass");
        else
            $display("sorted_array_priority_queue regression: fail");
        $finish;
    end

endmodule
